FILE: hdl/c_style_lexer_defines.svh
// Assertion macros shared by the lexer modules.
// Needs a clock aclk and an active-low reset aresetn in the including module.
`ifndef C_STYLE_LEXER_DEFINES_SVH
`define C_STYLE_LEXER_DEFINES_SVH

// Check that a condition holds at every edge out of reset.
`define CSL_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("lexer check failed");

// Check that a condition at one edge implies another at the next edge.
`define CSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lexer sequence check failed");

`endif

FILE: hdl/csl_pkg.sv
// Shared types, codes and character classes for the C-style lexer.
// No dependencies; every lexer module imports it.
package csl_pkg;

    // Lexer modes
    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_DOT    = 4'd1;
    localparam logic [3:0] M_SLASH  = 4'd2;
    localparam logic [3:0] M_DOTS   = 4'd3;
    localparam logic [3:0] M_IDENT  = 4'd4;
    localparam logic [3:0] M_SYM    = 4'd5;
    localparam logic [3:0] M_NINT   = 4'd6;
    localparam logic [3:0] M_NFRAC  = 4'd7;
    localparam logic [3:0] M_NESIGN = 4'd8;
    localparam logic [3:0] M_NEDIG  = 4'd9;
    localparam logic [3:0] M_STR    = 4'd10;
    localparam logic [3:0] M_STRESC = 4'd11;
    localparam logic [3:0] M_CBLK   = 4'd12;
    localparam logic [3:0] M_CSTAR  = 4'd13;
    localparam logic [3:0] M_CLINE  = 4'd14;

    // Token kinds
    localparam logic [2:0] K_PUNCT = 3'd0;
    localparam logic [2:0] K_DOTS  = 3'd1;
    localparam logic [2:0] K_STR   = 3'd2;
    localparam logic [2:0] K_IDENT = 3'd3;
    localparam logic [2:0] K_SYM   = 3'd4;
    localparam logic [2:0] K_NUM   = 3'd5;
    localparam logic [2:0] K_END   = 3'd6;

    // End marker status
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_CMT_OPEN = 2'd1;
    localparam logic [1:0] ST_STR_OPEN = 2'd2;

    // Register indexes (byte address / 8)
    localparam logic [1:0] REG_SYM_LO = 2'd0;
    localparam logic [1:0] REG_SYM_HI = 2'd1;
    localparam logic [1:0] REG_EXP_EN = 2'd2;

    // Characters
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_E_LO   = 8'h65;
    localparam logic [7:0] CH_E_UP   = 8'h45;

    // Result queue; depth must be a power of two, at least 2
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] kind;
        logic       last;
        logic [1:0] status;
    } csl_res_t;

    typedef struct packed {
        logic [127:0] sym_mask;
        logic         exp_en;
    } csl_cfg_t;

    typedef struct packed {
        logic room;
        logic nonempty;
    } csl_qstat_t;

    // What a byte does when it opens a token
    typedef struct packed {
        logic       emit;
        logic       last;
        logic       keep;
        logic [2:0] kind;
        logic [3:0] mode;
    } csl_start_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c inside {8'h28, 8'h29, 8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h2C, 8'h3B, 8'h25};
    endfunction

    // High codes are never symbolic
    function automatic logic is_sym(input logic [7:0] c, input logic [127:0] mask);
        return !c[7] && mask[c[6:0]];
    endfunction

    function automatic csl_start_t start_tok(input logic [7:0] c, input logic [127:0] mask);
        csl_start_t s;
        s = '{emit: 1'b0, last: 1'b0, keep: 1'b0, kind: K_PUNCT, mode: M_IDLE};
        if (is_punct(c)) begin
            s.emit = 1'b1;
            s.last = 1'b1;
        end else if (c == CH_DOT) begin
            s.keep = 1'b1; s.kind = K_DOTS; s.mode = M_DOT;
        end else if (c == CH_SLASH) begin
            s.keep = 1'b1; s.kind = K_SYM; s.mode = M_SLASH;
        end else if (c == CH_QUOTE) begin
            s.emit = 1'b1; s.kind = K_STR; s.mode = M_STR;
        end else if (is_alpha(c) || c == CH_US) begin
            s.keep = 1'b1; s.kind = K_IDENT; s.mode = M_IDENT;
        end else if (is_sym(c, mask)) begin
            s.keep = 1'b1; s.kind = K_SYM; s.mode = M_SYM;
        end else if (is_digit(c)) begin
            s.keep = 1'b1; s.kind = K_NUM; s.mode = M_NINT;
        end
        return s;
    endfunction

endpackage

FILE: hdl/c_style_lexer.sv
// Channel   | Dir | Signals                         | Word contents
// s_        | in  | s_tvalid s_tready s_tdata s_tlast | source byte, tlast = end of text
// m_        | out | m_tvalid m_tready m_tdata m_tuser m_tlast | token byte, kind, last
// APB       | in  | psel penable pwrite paddr pwdata prdata pready | masks, exponent enable
// One source word is taken per cycle while the queue has room; each yields zero,
// one or two result words. Results reach m_ through a four-word queue and then
// an output register, the second result of a word behind the first.
// A word is refused only while the queue has under two free slots.
// Sustained output is one word per cycle while m_tready is high, set by the single
// output register. Reset is synchronous on aresetn low.
module c_style_lexer
    import csl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_char
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] out_char, [9:8] status
    output logic [2:0]  m_tuser,    // [2:0] token_kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    csl_cfg_t   cfg;
    csl_qstat_t qstat;
    logic [1:0] push_cnt;
    csl_res_t   push_d0, push_d1, head;
    logic       pop;

    csl_regs u_regs (
        .aclk, .aresetn, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .cfg
    );

    csl_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tlast,
        .cfg, .qstat, .push_cnt, .push_d0, .push_d1
    );

    csl_queue u_queue (
        .aclk, .aresetn, .push_cnt, .push_d0, .push_d1, .pop, .head, .qstat
    );

    csl_back u_back (
        .aclk, .aresetn, .qstat, .head, .pop,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

endmodule

FILE: hdl/csl_regs.sv
// Configuration registers of the lexer behind an APB-style port.
// Depends on csl_pkg for register indexes and the config struct.
module csl_regs
    import csl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output csl_cfg_t    cfg
);

    logic [63:0] sym_lo_reg;
    logic [63:0] sym_hi_reg;
    logic        exp_en_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_lo_reg <= '0;
            sym_hi_reg <= '0;
            exp_en_reg <= 1'b1;
        end else if (wr_en) begin
            case (paddr[4:3])
                REG_SYM_LO: sym_lo_reg <= pwdata;
                REG_SYM_HI: sym_hi_reg <= pwdata;
                REG_EXP_EN: exp_en_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_SYM_LO: prdata = sym_lo_reg;
            REG_SYM_HI: prdata = sym_hi_reg;
            REG_EXP_EN: prdata = {63'd0, exp_en_reg};
            default:    prdata = '0;
        endcase
    end

    assign cfg = '{sym_mask: {sym_hi_reg, sym_lo_reg}, exp_en: exp_en_reg};

endmodule

FILE: hdl/csl_front.sv
// Front end: takes source words, runs the lexer mode machine, writes 0-2 results.
// Depends on csl_pkg and c_style_lexer_defines.svh.
`include "c_style_lexer_defines.svh"

module csl_front
    import csl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    input  csl_cfg_t   cfg,
    input  csl_qstat_t qstat,
    output logic [1:0] push_cnt,
    output csl_res_t   push_d0,
    output csl_res_t   push_d1
);

    logic [3:0] mode_reg, mode_next;
    logic [7:0] hb_reg, hb_next;
    logic [2:0] hk_reg, hk_next;
    logic       acc;
    logic       in_num;

    logic       p_valid, b_valid;
    csl_res_t   p_res, b_res;
    logic [1:0] cnt;

    assign s_tready = qstat.room;
    assign acc      = s_tvalid && s_tready;

    always_comb begin
        logic [7:0] c;
        logic       adv, more, do_begin;
        logic [3:0] adv_mode;
        logic [2:0] kind_eff;
        logic [1:0] st;
        csl_start_t s;

        c         = s_tdata;
        adv       = 1'b0;
        more      = 1'b0;
        do_begin  = 1'b0;
        adv_mode  = M_IDLE;
        kind_eff  = hk_reg;
        st        = ST_OK;
        s         = start_tok(c, cfg.sym_mask);
        mode_next = mode_reg;
        hb_next   = hb_reg;
        hk_next   = hk_reg;
        p_valid   = 1'b0;
        b_valid   = 1'b0;
        p_res     = '{ch: hb_reg, kind: hk_reg, last: 1'b0, status: ST_OK};
        b_res     = '{ch: c, kind: s.kind, last: s.last, status: ST_OK};

        if (s_tlast) begin
            // flush the held byte, then the end marker
            case (mode_reg)
                M_DOT: begin
                    p_valid = 1'b1;
                    p_res   = '{ch: hb_reg, kind: K_DOTS, last: 1'b1, status: ST_OK};
                end
                M_SLASH: begin
                    p_valid = is_sym(CH_SLASH, cfg.sym_mask);
                    p_res   = '{ch: hb_reg, kind: K_SYM, last: 1'b1, status: ST_OK};
                end
                M_DOTS, M_IDENT, M_SYM, M_NINT, M_NFRAC, M_NESIGN, M_NEDIG: begin
                    p_valid = 1'b1;
                    p_res   = '{ch: hb_reg, kind: hk_reg, last: 1'b1, status: ST_OK};
                end
                M_STR, M_STRESC: st = ST_STR_OPEN;
                M_CBLK, M_CSTAR: st = ST_CMT_OPEN;
                default: ;
            endcase
            b_valid   = 1'b1;
            b_res     = '{ch: 8'd0, kind: K_END, last: 1'b1, status: st};
            mode_next = M_IDLE;
        end else begin
            case (mode_reg)
                M_DOT: begin
                    adv = 1'b1;
                    if (!is_digit(c)) begin
                        kind_eff = K_DOTS; more = (c == CH_DOT); adv_mode = M_DOTS;
                    end else if (is_sym(CH_DOT, cfg.sym_mask)) begin
                        kind_eff = K_SYM; more = is_sym(c, cfg.sym_mask); adv_mode = M_SYM;
                    end else begin
                        kind_eff = K_NUM; more = 1'b1; adv_mode = M_NINT;
                    end
                end
                M_SLASH: begin
                    if (c == CH_STAR) begin
                        mode_next = M_CBLK;
                    end else if (c == CH_SLASH) begin
                        mode_next = M_CLINE;
                    end else if (is_sym(CH_SLASH, cfg.sym_mask)) begin
                        adv = 1'b1; kind_eff = K_SYM;
                        more = is_sym(c, cfg.sym_mask); adv_mode = M_SYM;
                    end else begin
                        do_begin = 1'b1;
                    end
                end
                M_DOTS: begin
                    adv = 1'b1; more = (c == CH_DOT); adv_mode = M_DOTS;
                end
                M_IDENT: begin
                    adv = 1'b1; more = is_alpha(c) || is_digit(c) || c == CH_US;
                    adv_mode = M_IDENT;
                end
                M_SYM: begin
                    adv = 1'b1; more = is_sym(c, cfg.sym_mask); adv_mode = M_SYM;
                end
                M_NINT, M_NFRAC: begin
                    adv = 1'b1;
                    if (is_digit(c)) begin
                        more = 1'b1; adv_mode = mode_reg;
                    end else if (c == CH_DOT && mode_reg == M_NINT) begin
                        more = 1'b1; adv_mode = M_NFRAC;
                    end else if (cfg.exp_en && (c == CH_E_LO || c == CH_E_UP)) begin
                        more = 1'b1; adv_mode = M_NESIGN;
                    end
                end
                M_NESIGN: begin
                    adv = 1'b1; more = c == CH_PLUS || c == CH_MINUS || is_digit(c);
                    adv_mode = M_NEDIG;
                end
                M_NEDIG: begin
                    adv = 1'b1; more = is_digit(c); adv_mode = M_NEDIG;
                end
                M_STR: begin
                    if (c == CH_QUOTE) begin
                        p_valid = 1'b1;
                        p_res   = '{ch: c, kind: K_STR, last: 1'b1, status: ST_OK};
                        mode_next = M_IDLE;
                    end else if (c == CH_BSLASH) begin
                        mode_next = M_STRESC;
                    end else begin
                        p_valid = 1'b1;
                        p_res   = '{ch: c, kind: K_STR, last: 1'b0, status: ST_OK};
                    end
                end
                M_STRESC: begin
                    p_valid   = 1'b1;
                    p_res     = '{ch: c, kind: K_STR, last: 1'b0, status: ST_OK};
                    mode_next = M_STR;
                end
                M_CBLK: begin
                    if (c == CH_STAR) mode_next = M_CSTAR;
                end
                M_CSTAR: begin
                    if (c == CH_SLASH) mode_next = M_IDLE;
                    else if (c != CH_STAR) mode_next = M_CBLK;
                end
                M_CLINE: begin
                    if (c == CH_NL) mode_next = M_IDLE;
                end
                default: do_begin = 1'b1;
            endcase

            // emit the held byte; keep the new one or start a fresh token
            if (adv) begin
                p_valid = 1'b1;
                p_res   = '{ch: hb_reg, kind: kind_eff, last: !more, status: ST_OK};
                if (more) begin
                    hb_next   = c;
                    hk_next   = kind_eff;
                    mode_next = adv_mode;
                end else begin
                    do_begin = 1'b1;
                end
            end

            if (do_begin) begin
                b_valid   = s.emit;
                mode_next = s.mode;
                if (s.keep) begin
                    hb_next = c;
                    hk_next = s.kind;
                end
            end
        end
    end

    assign cnt      = {1'b0, p_valid} + {1'b0, b_valid};
    assign push_cnt = acc ? cnt : 2'd0;
    assign push_d0  = p_valid ? p_res : b_res;
    assign push_d1  = b_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
        end else if (acc) begin
            mode_reg <= mode_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            hb_reg <= hb_next;
            hk_reg <= hk_next;
        end
    end

    assign in_num = mode_reg inside {M_NINT, M_NFRAC, M_NESIGN, M_NEDIG};

    `CSL_ASSERT_NEXT(a_end_to_idle, acc && s_tlast, mode_reg == M_IDLE)
    `CSL_ASSERT(a_ident_kind, (mode_reg != M_IDENT) || (hk_reg == K_IDENT))
    `CSL_ASSERT(a_num_kind, !in_num || (hk_reg == K_NUM))

endmodule

FILE: hdl/csl_queue.sv
// Short result queue between front and back; takes up to two words a cycle.
// Depends on csl_pkg and c_style_lexer_defines.svh.
`include "c_style_lexer_defines.svh"

module csl_queue
    import csl_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  csl_res_t   push_d0,
    input  csl_res_t   push_d1,
    input  logic       pop,
    output csl_res_t   head,
    output csl_qstat_t qstat
);

    csl_res_t         mem [QDEPTH];
    logic [QAW-1:0]   wp_reg, rp_reg;
    logic [QAW:0]     count_reg, count_next;
    logic [QAW-1:0]   wp_inc;

    assign wp_inc = wp_reg + QAW'(1);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) mem[wp_reg] <= push_d0;
        if (push_cnt == 2'd2) mem[wp_inc] <= push_d1;
    end

    assign count_next = count_reg + (QAW+1)'(push_cnt) - (QAW+1)'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end else begin
            wp_reg    <= wp_reg + QAW'(push_cnt);
            rp_reg    <= rp_reg + QAW'(pop);
            count_reg <= count_next;
        end
    end

    assign head           = mem[rp_reg];
    assign qstat.nonempty = count_reg != '0;
    assign qstat.room     = count_reg <= (QAW+1)'(QDEPTH - 2);

    `CSL_ASSERT(a_no_overfill, count_reg <= (QAW+1)'(QDEPTH))
    `CSL_ASSERT(a_push_room, (push_cnt == 2'd0) || qstat.room)
    `CSL_ASSERT(a_pop_nonempty, !pop || qstat.nonempty)

endmodule

FILE: hdl/csl_back.sv
// Back end: drains the result queue into the output register of the result stream.
// Depends on csl_pkg.
module csl_back
    import csl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  csl_qstat_t  qstat,
    input  csl_res_t    head,
    output logic        pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic     valid_reg, valid_next;
    csl_res_t out_reg;

    // advance when the output register is empty or being taken
    assign pop        = qstat.nonempty && (!valid_reg || m_tready);
    assign valid_next = pop || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) out_reg <= head;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'd0, out_reg.status, out_reg.ch};
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;

endmodule

FILE: tb/sv/c_style_lexer_tb.sv
// Self-checking bench for c_style_lexer: streams source bytes through the lexer
// and checks every token word against a predictor kept in step on the input side.
// Depends on csl_pkg for the mode, kind, status, register and character codes.
module c_style_lexer_tb;
    import csl_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_WORDS     = 270;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } src_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] in_char
    logic        s_tlast = 1'b0;   // end of text
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // [7:0] out_char, [9:8] status
    logic [2:0]  m_tuser;          // [2:0] token_kind
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    c_style_lexer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
        .prdata(prdata), .pready(pready)
    );

    always #2 aclk = ~aclk;

    src_word_t  src_q[$];
    csl_res_t   token_q[$];
    int         src_pct = 0;
    int         snk_pct = 0;
    bit         hold_off_req = 1'b0;
    logic       sink_held = 1'b0;
    int         fault_count = 0;
    int         words_taken = 0;
    int         tokens_checked = 0;
    int         end_marks = 0;
    int         cycles = 0;

    // Lexer state and settings as the bench sees them
    logic [127:0] sym_mask = '0;
    logic         exp_on = 1'b1;
    logic [3:0]   lex_mode = M_IDLE;
    logic [7:0]   held_ch = '0;
    logic [2:0]   held_k = K_PUNCT;

    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= 40) $display("[%0d] mismatch: %s", cycles, msg);
    endtask

    function automatic logic char_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic char_letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic char_symbolic(input logic [7:0] c);
        return !c[7] && sym_mask[c[6:0]];
    endfunction

    function automatic logic char_punct(input logic [7:0] c);
        return c inside {"(", ")", "{", "}", "[", "]", ",", ";", "%"};
    endfunction

    function automatic logic exp_char(input logic [7:0] c);
        return exp_on && (c == CH_E_LO || c == CH_E_UP);
    endfunction

    function automatic void push_token(input logic [7:0] c, input logic [2:0] k,
                                       input logic l, input logic [1:0] st);
        csl_res_t r;
        r.ch = c;
        r.kind = k;
        r.last = l;
        r.status = st;
        token_q.push_back(r);
    endfunction

    function automatic void keep_byte(input logic [7:0] c, input logic [2:0] k,
                                      input logic [3:0] md);
        held_ch = c;
        held_k = k;
        lex_mode = md;
    endfunction

    function automatic void drop_held(input logic [3:0] md);
        held_ch = '0;
        held_k = K_PUNCT;
        lex_mode = md;
    endfunction

    function automatic void open_token(input logic [7:0] c);
        if (char_punct(c)) begin
            push_token(c, K_PUNCT, 1'b1, ST_OK);
            drop_held(M_IDLE);
        end else if (c == CH_DOT) begin
            keep_byte(c, K_DOTS, M_DOT);
        end else if (c == CH_SLASH) begin
            keep_byte(c, K_SYM, M_SLASH);
        end else if (c == CH_QUOTE) begin
            push_token(c, K_STR, 1'b0, ST_OK);
            drop_held(M_STR);
        end else if (char_letter(c) || c == CH_US) begin
            keep_byte(c, K_IDENT, M_IDENT);
        end else if (char_symbolic(c)) begin
            keep_byte(c, K_SYM, M_SYM);
        end else if (char_digit(c)) begin
            keep_byte(c, K_NUM, M_NINT);
        end else begin
            drop_held(M_IDLE);
        end
    endfunction

    // Release the held byte: mid-token if the token goes on, else final and restart
    function automatic void step_on(input logic [7:0] c, input logic more,
                                    input logic [3:0] next_md);
        if (more) begin
            push_token(held_ch, held_k, 1'b0, ST_OK);
            keep_byte(c, held_k, next_md);
        end else begin
            push_token(held_ch, held_k, 1'b1, ST_OK);
            drop_held(M_IDLE);
            open_token(c);
        end
    endfunction

    function automatic void lex_byte(input logic [7:0] c);
        case (lex_mode)
            M_DOT: begin
                if (!char_digit(c)) begin
                    held_k = K_DOTS;
                    step_on(c, c == CH_DOT, M_DOTS);
                end else if (char_symbolic(CH_DOT)) begin
                    held_k = K_SYM;
                    step_on(c, char_symbolic(c), M_SYM);
                end else begin
                    held_k = K_NUM;
                    step_on(c, 1'b1, M_NINT);
                end
            end
            M_SLASH: begin
                if (c == CH_STAR) drop_held(M_CBLK);
                else if (c == CH_SLASH) drop_held(M_CLINE);
                else if (char_symbolic(CH_SLASH)) begin
                    held_k = K_SYM;
                    step_on(c, char_symbolic(c), M_SYM);
                end else begin
                    drop_held(M_IDLE);
                    open_token(c);
                end
            end
            M_DOTS:  step_on(c, c == CH_DOT, M_DOTS);
            M_IDENT: step_on(c, char_letter(c) || char_digit(c) || c == CH_US, M_IDENT);
            M_SYM:   step_on(c, char_symbolic(c), M_SYM);
            M_NINT: begin
                if (char_digit(c)) step_on(c, 1'b1, M_NINT);
                else if (c == CH_DOT) step_on(c, 1'b1, M_NFRAC);
                else if (exp_char(c)) step_on(c, 1'b1, M_NESIGN);
                else step_on(c, 1'b0, M_IDLE);
            end
            M_NFRAC: begin
                if (char_digit(c)) step_on(c, 1'b1, M_NFRAC);
                else if (exp_char(c)) step_on(c, 1'b1, M_NESIGN);
                else step_on(c, 1'b0, M_IDLE);
            end
            M_NESIGN: step_on(c, c == CH_PLUS || c == CH_MINUS || char_digit(c), M_NEDIG);
            M_NEDIG:  step_on(c, char_digit(c), M_NEDIG);
            M_STR: begin
                if (c == CH_QUOTE) begin
                    push_token(c, K_STR, 1'b1, ST_OK);
                    drop_held(M_IDLE);
                end else if (c == CH_BSLASH) begin
                    drop_held(M_STRESC);
                end else begin
                    push_token(c, K_STR, 1'b0, ST_OK);
                end
            end
            M_STRESC: begin
                push_token(c, K_STR, 1'b0, ST_OK);
                drop_held(M_STR);
            end
            M_CBLK:  if (c == CH_STAR) drop_held(M_CSTAR);
            M_CSTAR: begin
                if (c == CH_SLASH) drop_held(M_IDLE);
                else if (c != CH_STAR) drop_held(M_CBLK);
            end
            M_CLINE: if (c == CH_NL) drop_held(M_IDLE);
            default: open_token(c);
        endcase
    endfunction

    function automatic void lex_end();
        logic [1:0] st;
        st = ST_OK;
        case (lex_mode)
            M_DOT:   push_token(held_ch, K_DOTS, 1'b1, ST_OK);
            M_SLASH: if (char_symbolic(CH_SLASH)) push_token(held_ch, K_SYM, 1'b1, ST_OK);
            M_DOTS, M_IDENT, M_SYM, M_NINT, M_NFRAC, M_NESIGN, M_NEDIG:
                push_token(held_ch, held_k, 1'b1, ST_OK);
            M_STR, M_STRESC: st = ST_STR_OPEN;
            M_CBLK, M_CSTAR: st = ST_CMT_OPEN;
            default: ;
        endcase
        push_token(8'h00, K_END, 1'b1, st);
        drop_held(M_IDLE);
    endfunction

    // Source side: hold a word until taken, then offer the next or idle
    always @(posedge aclk) begin
        src_word_t w;
        bit        give;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                if (s_tlast) lex_end();
                else lex_byte(s_tdata);
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                give = src_q.size() != 0 && $urandom_range(99) >= src_pct;
                if (give) begin
                    w = src_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= w.ch;
                    s_tlast  <= w.eot;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: check each accepted word against the oldest expected token
    always @(posedge aclk) begin
        csl_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    report_fault($sformatf("unexpected word ch=%02h kind=%0d",
                                           m_tdata[7:0], m_tuser));
                end else begin
                    want = token_q.pop_front();
                    tokens_checked++;
                    if (want.kind == K_END) end_marks++;
                    if (m_tdata[7:0] !== want.ch)
                        report_fault($sformatf("out_char %02h, expected %02h",
                                               m_tdata[7:0], want.ch));
                    if (m_tuser !== want.kind)
                        report_fault($sformatf("token_kind %0d, expected %0d",
                                               m_tuser, want.kind));
                    if (m_tlast !== want.last)
                        report_fault($sformatf("last_of_token %0b, expected %0b",
                                               m_tlast, want.last));
                    if (m_tdata[9:8] !== want.status)
                        report_fault($sformatf("status %0d, expected %0d",
                                               m_tdata[9:8], want.status));
                end
            end
            m_tready <= !sink_held && $urandom_range(99) >= snk_pct;
        end
    end

    // Long receiver hold-off, counted here
    initial begin
        wait (hold_off_req);
        @(posedge aclk);
        sink_held <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        sink_held <= 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens outstanding", cycles, token_q.size());
            $display("c_style_lexer_tb: FAIL");
            $finish;
        end
    end

    function automatic void push_char(input logic [7:0] c);
        src_word_t w;
        w.ch = c;
        w.eot = 1'b0;
        src_q.push_back(w);
    endfunction

    function automatic void push_end();
        src_word_t w;
        w.ch = 8'($urandom_range(255));
        w.eot = 1'b1;
        src_q.push_back(w);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) push_char(s[i]);
    endfunction

    function automatic logic [7:0] pick(input string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    // One piece of source text: mostly well-formed tokens, some noise and breakage
    function automatic void add_fragment();
        string letters, digits, ops;
        int    r, n;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
        digits  = "0123456789";
        ops     = "+-*/=<>!&|^~?:#$@.";
        r = $urandom_range(99);
        if (r < 16) begin
            push_char(pick(letters));
            n = $urandom_range(6);
            repeat (n) push_char($urandom_range(3) == 0 ? pick(digits) : pick(letters));
        end else if (r < 32) begin
            if ($urandom_range(6) == 0) push_char(CH_DOT);
            n = $urandom_range(1, 4);
            repeat (n) push_char(pick(digits));
            if ($urandom_range(1)) begin
                push_char(CH_DOT);
                n = $urandom_range(3);
                repeat (n) push_char(pick(digits));
            end
            if ($urandom_range(2) == 0) begin
                push_char($urandom_range(1) ? CH_E_LO : CH_E_UP);
                if ($urandom_range(1)) push_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
                n = $urandom_range(2);
                repeat (n) push_char(pick(digits));
            end
        end else if (r < 44) begin
            push_char(CH_QUOTE);
            n = $urandom_range(6);
            repeat (n) begin
                case ($urandom_range(9))
                    0, 1:    begin
                        push_char(CH_BSLASH);
                        push_char(8'($urandom_range(255)));
                    end
                    2:       push_char(8'($urandom_range(255)));
                    default: push_char(pick(letters));
                endcase
            end
            if ($urandom_range(99) < 85) push_char(CH_QUOTE);
        end else if (r < 52) begin
            push_text("/*");
            n = $urandom_range(6);
            repeat (n)
                push_char($urandom_range(3) == 0 ? 8'($urandom_range(255)) : pick("*/ab\n"));
            if ($urandom_range(99) < 85) push_text("*/");
        end else if (r < 58) begin
            push_text("//");
            n = $urandom_range(5);
            repeat (n) push_char(8'($urandom_range(255)));
            push_char(CH_NL);
        end else if (r < 63) begin
            n = $urandom_range(1, 4);
            repeat (n) push_char(CH_DOT);
        end else if (r < 73) begin
            n = $urandom_range(1, 4);
            repeat (n) push_char(pick(ops));
        end else if (r < 83) begin
            push_char(pick("(){}[],;%"));
        end else if (r < 90) begin
            push_char(pick(" \t\n"));
        end else if (r < 97) begin
            push_char(8'($urandom_range(255)));
        end else begin
            push_end();
        end
        if ($urandom_range(1)) push_char(pick(" \t\n"));
    endfunction

    // Wait for every word to be taken and every token to arrive, then let the pipe empty
    task automatic settle();
        while (src_q.size() != 0 || s_tvalid || token_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SYM_LO: sym_mask[63:0] = val;
            REG_SYM_HI: sym_mask[127:64] = val;
            REG_EXP_EN: exp_on = val[0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [127:0] mask, input logic en, input int sp,
                             input int rp, input string lead, input bit press);
        settle();
        write_reg(REG_SYM_LO, mask[63:0]);
        write_reg(REG_SYM_HI, mask[127:64]);
        write_reg(REG_EXP_EN, {63'd0, en});
        src_pct = sp;
        snk_pct = rp;
        push_text(lead);
        if (lead.len() != 0) push_end();
        while (src_q.size() < PHASE_WORDS) add_fragment();
        push_end();
        if (press) hold_off_req = 1'b1;
    endtask

    function automatic logic [127:0] operator_mask();
        string ops;
        logic [127:0] m;
        logic [7:0] b;
        ops = "+-*/=<>!&|^~?:#$@.";
        m = '0;
        for (int i = 0; i < ops.len(); i++) begin
            b = ops[i];
            m[b[6:0]] = 1'b1;
        end
        return m;
    endfunction

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: every punctuation byte, ident, number with bare exponent,
        // high code ending a token, dot run, escaped quote, high code in an open string
        push_text("(){}[],;%_9 1.e+");
        push_char(8'h80);
        push_text("..\"\\\"");
        push_char(8'hFF);
        push_end();

        // Dot before a digit as a symbol, slash symbol run, comment left open by "/*/"
        run_phase(operator_mask(), 1'b1, 0, 0, ".5/= /*/", 1'b0);
        run_phase({128{1'b1}}, 1'b0, 64, 0, "", 1'b0);
        run_phase('0, 1'b1, 0, 64, "", 1'b0);
        run_phase({$urandom, $urandom, $urandom, $urandom}, 1'($urandom_range(1)),
                  33, 33, "", 1'b0);
        // Receiver holds off while the sender keeps offering
        run_phase(operator_mask(), 1'b0, 0, 0, "", 1'b1);
        run_phase({$urandom, $urandom, $urandom, $urandom}, 1'b1, 0, 0, "", 1'b0);
        settle();

        $display("%0d source words lexed under 7 settings, %0d token words checked",
                 words_taken, tokens_checked);
        $display("%0d end markers seen, %0d mismatches", end_marks, fault_count);
        if (fault_count == 0) $display("c_style_lexer_tb: PASS");
        else $display("c_style_lexer_tb: FAIL");
        $finish;
    end

endmodule
